FILE: rtl/spi_master_word_engine_core_macros.svh
// ----------------------------------------------------------------------------
// SPI master word engine: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_WORD_ENGINE_CORE_MACROS_SVH
`define SPI_MASTER_WORD_ENGINE_CORE_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define SMWE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the following cycle.
`define SMWE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/smwe_pkg.sv
// ----------------------------------------------------------------------------
// SPI master word engine: package
// Shared widths, register map codes and the structs passed between modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smwe_pkg;

  // Fixed payload widths.
  localparam int unsigned WORD_W        = 16;
  localparam int unsigned TICK_W        = 8;
  localparam int unsigned CFG_ADDR_W    = 4;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned WORD_BITS_DEF = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [TICK_W-1:0] tick_t;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_PRESCALE = 2'd0;
  localparam logic [1:0] REG_CPOL     = 2'd1;
  localparam logic [1:0] REG_CPHA     = 2'd2;

  localparam tick_t PRESCALE_RESET = 8'd1;

  // Live configuration handed to the engine.
  typedef struct packed {
    tick_t prescale;
    logic  clock_polarity;
    logic  clock_phase;
  } cfg_t;

  // One result beat.
  typedef struct packed {
    logic  sclk_level;
    logic  mosi_level;
    logic  chip_select_n;
    logic  tx_full;
    word_t rx_word;
    logic  rx_valid;
  } res_t;

endpackage

FILE: rtl/smwe_in_if.sv
// ----------------------------------------------------------------------------
// SPI master word engine: input channel
// Valid/ready channel carrying one tick beat with an optional transmit word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smwe_in_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [smwe_pkg::WORD_W-1:0] tx_word;
  logic                        end_of_transfer;
  logic                        miso_level;

  modport source (output valid, command, tx_word, end_of_transfer, miso_level,
                  input ready);
  modport sink   (input valid, command, tx_word, end_of_transfer, miso_level,
                  output ready);
endinterface

FILE: rtl/smwe_out_if.sv
// ----------------------------------------------------------------------------
// SPI master word engine: result channel
// Valid/ready channel carrying the pin levels and status after one tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface smwe_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sclk_level;
  logic                        mosi_level;
  logic                        chip_select_n;
  logic                        tx_full;
  logic [smwe_pkg::WORD_W-1:0] rx_word;
  logic                        rx_valid;

  modport source (output valid, sclk_level, mosi_level, chip_select_n, tx_full,
                  rx_word, rx_valid, input ready);
  modport sink   (input valid, sclk_level, mosi_level, chip_select_n, tx_full,
                  rx_word, rx_valid, output ready);
endinterface

FILE: rtl/smwe_cfg_regs.sv
// ----------------------------------------------------------------------------
// SPI master word engine: configuration registers
// APB-style register file holding prescale, clock polarity and clock phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smwe_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smwe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [smwe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [smwe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  output smwe_pkg::cfg_t                  cfg
);
  import smwe_pkg::*;

  tick_t prescale_r;
  logic  cpol_r;
  logic  cpha_r;
  logic  wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes land on the access cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= PRESCALE_RESET;
      cpol_r     <= 1'b0;
      cpha_r     <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_PRESCALE: prescale_r <= pwdata[TICK_W-1:0];
        REG_CPOL:     cpol_r     <= pwdata[0];
        REG_CPHA:     cpha_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PRESCALE: prdata = CFG_DATA_W'(prescale_r);
      REG_CPOL:     prdata = CFG_DATA_W'(cpol_r);
      REG_CPHA:     prdata = CFG_DATA_W'(cpha_r);
      default:      prdata = '0;
    endcase
  end

  assign cfg = '{prescale: prescale_r, clock_polarity: cpol_r, clock_phase: cpha_r};

endmodule

FILE: rtl/smwe_engine.sv
// ----------------------------------------------------------------------------
// SPI master word engine: bit engine
// Holds the shifter, transmit buffer and bit timer, and advances them by one
// tick per accepted beat. The result reflects the state after that tick.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "spi_master_word_engine_core_macros.svh"

module smwe_engine #(
  parameter int unsigned WORD_BITS = smwe_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step_en,
  input  smwe_pkg::cfg_t              cfg,
  input  logic                        command,
  input  logic [smwe_pkg::WORD_W-1:0] tx_word,
  input  logic                        end_of_transfer,
  input  logic                        miso_level,
  output smwe_pkg::res_t              res
);
  import smwe_pkg::*;

  localparam int unsigned BL_W = $clog2(WORD_BITS + 1);
  localparam logic [BL_W-1:0] BITS_FULL = BL_W'(WORD_BITS);
  localparam logic [BL_W-1:0] BITS_ONE  = BL_W'(1);

  logic [WORD_BITS-1:0] shift_out_r, shift_out_nxt;
  logic [WORD_BITS-1:0] shift_in_r,  shift_in_nxt;
  logic [WORD_BITS-1:0] pend_word_r, pend_word_nxt;
  logic [WORD_BITS-1:0] recv_r,      recv_nxt;
  logic                 pend_valid_r, pend_valid_nxt;
  logic                 pend_end_r,   pend_end_nxt;
  logic                 active_end_r, active_end_nxt;
  logic                 select_r,     select_nxt;
  logic [BL_W-1:0]      bits_left_r,  bits_left_nxt;
  tick_t                tick_r,       tick_nxt;

  tick_t p_eff;
  tick_t half1;
  logic  released;
  logic  rx_pulse;
  logic  first_half;

  // One tick of the master: buffer load, bit timer, then word start.
  always_comb begin
    p_eff = (cfg.prescale == '0) ? PRESCALE_RESET : cfg.prescale;
    half1 = TICK_W'(({1'b0, p_eff} + 9'd2) >> 1);

    shift_out_nxt  = shift_out_r;
    shift_in_nxt   = shift_in_r;
    pend_word_nxt  = pend_word_r;
    recv_nxt       = recv_r;
    pend_valid_nxt = pend_valid_r;
    pend_end_nxt   = pend_end_r;
    active_end_nxt = active_end_r;
    select_nxt     = select_r;
    bits_left_nxt  = bits_left_r;
    tick_nxt       = tick_r;
    released       = 1'b0;
    rx_pulse       = 1'b0;

    // A load while the buffer is full is dropped with its end mark.
    if (command && !pend_valid_r) begin
      pend_word_nxt  = tx_word[WORD_BITS-1:0];
      pend_end_nxt   = end_of_transfer;
      pend_valid_nxt = 1'b1;
    end

    if (bits_left_r != '0) begin
      if (tick_r >= p_eff) begin
        // End of bit: shift the next bit out, close the word on the last one.
        tick_nxt      = '0;
        shift_out_nxt = {shift_out_r[WORD_BITS-2:0], 1'b0};
        bits_left_nxt = bits_left_r - BITS_ONE;
        if (bits_left_r == BITS_ONE) begin
          recv_nxt = shift_in_r;
          rx_pulse = 1'b1;
          if (active_end_r) begin
            select_nxt = 1'b0;
            released   = 1'b1;
          end
          active_end_nxt = 1'b0;
        end
      end else begin
        // Mid-bit sample point.
        tick_nxt = tick_r + 8'd1;
        if (tick_nxt == half1) begin
          shift_in_nxt = {shift_in_r[WORD_BITS-2:0], miso_level};
        end
      end
    end

    // Start a buffered word unless chip select was just released.
    if (bits_left_nxt == '0 && pend_valid_nxt && !released) begin
      shift_out_nxt  = pend_word_nxt;
      shift_in_nxt   = '0;
      active_end_nxt = pend_end_nxt;
      pend_valid_nxt = 1'b0;
      pend_end_nxt   = 1'b0;
      bits_left_nxt  = BITS_FULL;
      tick_nxt       = '0;
      select_nxt     = 1'b1;
    end

    // Pin levels after this tick.
    first_half = (tick_nxt < half1);
    res.chip_select_n = ~select_nxt;
    res.tx_full       = pend_valid_nxt;
    res.rx_word       = WORD_W'(recv_nxt);
    res.rx_valid      = rx_pulse;
    if (bits_left_nxt != '0) begin
      res.sclk_level = cfg.clock_polarity ^ first_half ^ ~cfg.clock_phase;
      res.mosi_level = shift_out_nxt[WORD_BITS-1];
    end else begin
      res.sclk_level = cfg.clock_polarity;
      res.mosi_level = 1'b0;
    end
  end

  // State update on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_out_r  <= '0;
      shift_in_r   <= '0;
      pend_word_r  <= '0;
      recv_r       <= '0;
      pend_valid_r <= 1'b0;
      pend_end_r   <= 1'b0;
      active_end_r <= 1'b0;
      select_r     <= 1'b0;
      bits_left_r  <= '0;
      tick_r       <= '0;
    end else if (step_en) begin
      shift_out_r  <= shift_out_nxt;
      shift_in_r   <= shift_in_nxt;
      pend_word_r  <= pend_word_nxt;
      recv_r       <= recv_nxt;
      pend_valid_r <= pend_valid_nxt;
      pend_end_r   <= pend_end_nxt;
      active_end_r <= active_end_nxt;
      select_r     <= select_nxt;
      bits_left_r  <= bits_left_nxt;
      tick_r       <= tick_nxt;
    end
  end

  // A word in flight always has chip select asserted.
  `SMWE_ASSERT_SAME(a_busy_selects, bits_left_r != '0, select_r, "word active without select")
  // The bit timer rests at zero while idle.
  `SMWE_ASSERT_SAME(a_idle_tick_zero, bits_left_r == '0, tick_r == '0, "idle with tick running")
  // Finishing the last bit either goes idle or starts the buffered word.
  `SMWE_ASSERT_NEXT(a_last_bit, step_en && bits_left_r == BITS_ONE && tick_r >= p_eff,
    bits_left_r == '0 || bits_left_r == BITS_FULL, "bad bit count after word end")

endmodule

FILE: rtl/spi_master_word_engine_core.sv
// ----------------------------------------------------------------------------
// SPI master word engine: top level
// Usage:
//   in_ch carries one beat per system tick: an optional transmit word load
//   (command, tx_word, end_of_transfer) and the sampled MISO level.
//   out_ch returns one beat per input beat with SCLK, MOSI, chip select,
//   the transmit-buffer-full flag and the last received word with its pulse.
//   The APB port (psel/penable/pwrite/paddr/pwdata) sets prescale at 0x0,
//   clock polarity at 0x4 and clock phase at 0x8; pready is tied high.
// Timing:
//   An accepted input beat has its result beat in the output register on
//   the next cycle. Throughput is one beat per cycle unless out_ch stalls:
//   the engine takes one tick per beat and the output register refills as it drains.
// Reset:
//   Synchronous rst_n returns to idle: buffer empty, chip select released,
//   prescale 1, polarity 0, phase 0, no result held.
// Stalls:
//   While out_ch.ready is low and a result is held, in_ch.ready drops and the
//   engine state holds; no beat is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "spi_master_word_engine_core_macros.svh"

module spi_master_word_engine_core #(
  parameter int unsigned WORD_BITS = smwe_pkg::WORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  smwe_in_if.sink                         in_ch,
  smwe_out_if.source                      out_ch,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [smwe_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [smwe_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [smwe_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import smwe_pkg::*;

  cfg_t cfg;
  res_t res;
  res_t res_r;
  logic out_valid_r;
  logic in_beat;

  // Configuration registers.
  smwe_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input accepted when the output register is empty or draining.
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign in_beat     = in_ch.valid & in_ch.ready;

  // Bit engine.
  smwe_engine #(
    .WORD_BITS (WORD_BITS)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (in_beat),
    .cfg             (cfg),
    .command         (in_ch.command),
    .tx_word         (in_ch.tx_word),
    .end_of_transfer (in_ch.end_of_transfer),
    .miso_level      (in_ch.miso_level),
    .res             (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      out_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sclk_level    = res_r.sclk_level;
  assign out_ch.mosi_level    = res_r.mosi_level;
  assign out_ch.chip_select_n = res_r.chip_select_n;
  assign out_ch.tx_full       = res_r.tx_full;
  assign out_ch.rx_word       = res_r.rx_word;
  assign out_ch.rx_valid      = res_r.rx_valid;

  // An accepted beat always produces a held result next cycle.
  `SMWE_ASSERT_NEXT(a_beat_fills, in_beat, out_valid_r, "accepted beat not registered")
  // A held result that is not taken blocks new input.
  `SMWE_ASSERT_SAME(a_no_overwrite, out_valid_r && !out_ch.ready, !in_ch.ready,
    "result overwritten while stalled")
  // A result only appears after an accepted beat.
  `SMWE_ASSERT_SAME(a_result_source, $rose(out_valid_r), $past(in_beat),
    "result without input beat")

endmodule
